### rtl/ljf_pkg.sv
// Shared widths, limits, state type and control structs of the longest-job-first scheduler.
package ljf_pkg;

  // Fixed field widths of the request channels
  localparam int unsigned BURST_W  = 16;
  localparam int unsigned JOB_ID_W = 7;
  localparam int unsigned WAIT_W   = 22;
  localparam int unsigned TOTAL_W  = 28;

  // Saturation limits of the time sums
  localparam logic [WAIT_W-1:0]  WAIT_MAX  = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Controller states: loading a batch, or streaming the schedule out
  typedef enum logic [0:0] {
    ST_LOAD,
    ST_EMIT
  } ljf_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take_in;
    logic pop;
  } ljf_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_valid;
    logic in_last;
    logic out_free;
    logic last_pop;
  } ljf_sts_t;

endpackage

### rtl/ljf_if.sv
// Input and result channel interfaces of the longest-job-first scheduler.
interface ljf_in_if import ljf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BURST_W-1:0] burst;
  logic               batch_end;

  modport source (output valid, output burst, output batch_end, input ready);
  modport sink   (input valid, input burst, input batch_end, output ready);
endinterface

interface ljf_out_if import ljf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [JOB_ID_W-1:0] job_id;
  logic [BURST_W-1:0]  job_burst;
  logic [WAIT_W-1:0]   wait_time;
  logic [WAIT_W-1:0]   turnaround;
  logic [TOTAL_W-1:0]  total_wait;
  logic [TOTAL_W-1:0]  total_turnaround;
  logic                final_res;
  logic                dropped;

  modport source (output valid, output job_id, output job_burst, output wait_time,
                  output turnaround, output total_wait, output total_turnaround,
                  output final_res, output dropped, input ready);
  modport sink   (input valid, input job_id, input job_burst, input wait_time,
                  input turnaround, input total_wait, input total_turnaround,
                  input final_res, input dropped, output ready);
endinterface

### rtl/ljf_ctrl.sv
// Controller state machine: alternates between loading a batch and emitting its schedule.
module ljf_ctrl import ljf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  ljf_sts_t sts,
  output ljf_cmd_t cmd
);

  ljf_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: a request marked last starts the schedule, the final pop ends it.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (sts.in_valid && sts.in_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free && sts.last_pop) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Outputs: take requests while loading, pop one job whenever the output register frees.
  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_LOAD: cmd.take_in = 1'b1;
      ST_EMIT: cmd.pop     = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

### rtl/ljf_dp.sv
// Datapath: sorted insertion cell array, schedule accumulators and result register.
module ljf_dp import ljf_pkg::*; #(
  parameter int unsigned MAX_JOBS   = 64,
  parameter int unsigned BURST_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  ljf_in_if.sink          in_chan,
  ljf_out_if.source       out_chan,
  input  ljf_cmd_t        cmd,
  output ljf_sts_t        sts
);

  localparam int unsigned SB_W  = (BURST_BITS < BURST_W) ? BURST_BITS : BURST_W;
  localparam int unsigned CNT_W = $clog2(MAX_JOBS + 1);
  localparam int unsigned IDX_W = $clog2(MAX_JOBS);

  // Cell array, kept in descending burst order from cell 0
  logic [SB_W-1:0]  cell_burst_r [MAX_JOBS];
  logic [IDX_W-1:0] cell_id_r    [MAX_JOBS];
  logic [MAX_JOBS-1:0] keep;

  logic [CNT_W-1:0]   cnt_r;
  logic               ovf_r;
  logic [WAIT_W-1:0]  wait_r;
  logic [TOTAL_W-1:0] totw_r;
  logic [TOTAL_W-1:0] tott_r;

  logic                out_valid_r;
  logic [JOB_ID_W-1:0] job_id_r;
  logic [BURST_W-1:0]  job_burst_r;
  logic [WAIT_W-1:0]   wait_time_r;
  logic [WAIT_W-1:0]   turnaround_r;
  logic [TOTAL_W-1:0]  total_wait_r;
  logic [TOTAL_W-1:0]  total_turn_r;
  logic                final_r;
  logic                dropped_r;

  logic [SB_W-1:0]    new_burst;
  logic [IDX_W-1:0]   new_id;
  logic               accept;
  logic               full;
  logic               insert;
  logic               last_pop;
  logic               out_free;
  logic [WAIT_W:0]    ta_sum;
  logic [WAIT_W-1:0]  ta;
  logic [TOTAL_W:0]   tw_sum;
  logic [TOTAL_W:0]   tt_sum;
  logic [TOTAL_W-1:0] tw;
  logic [TOTAL_W-1:0] tt;

  // Request handshake and the incoming job
  assign in_chan.ready = cmd.take_in;
  assign accept        = in_chan.valid && cmd.take_in;
  assign new_burst     = in_chan.burst[SB_W-1:0];
  assign new_id        = cnt_r[IDX_W-1:0];
  assign full          = (cnt_r == CNT_W'(MAX_JOBS));
  assign insert        = accept && !full;

  // Each held cell whose burst is at least the new one stays put; equal bursts keep order.
  always_comb begin
    for (int i = 0; i < MAX_JOBS; i++) begin
      keep[i] = (CNT_W'(i) < cnt_r) && (cell_burst_r[i] >= new_burst);
    end
  end

  // Cells: on insert, the first non-kept cell takes the new job and later cells shift down;
  // on pop, every cell takes its successor.
  for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
    logic [SB_W-1:0]  prev_burst;
    logic [IDX_W-1:0] prev_id;
    logic             prev_keep;
    logic [SB_W-1:0]  next_burst;
    logic [IDX_W-1:0] next_id;

    if (i == 0) begin : g_head
      assign prev_burst = new_burst;
      assign prev_id    = new_id;
      assign prev_keep  = 1'b1;
    end else begin : g_body
      assign prev_burst = cell_burst_r[i-1];
      assign prev_id    = cell_id_r[i-1];
      assign prev_keep  = keep[i-1];
    end

    if (i == MAX_JOBS - 1) begin : g_tail
      assign next_burst = cell_burst_r[i];
      assign next_id    = cell_id_r[i];
    end else begin : g_link
      assign next_burst = cell_burst_r[i+1];
      assign next_id    = cell_id_r[i+1];
    end

    always_ff @(posedge clk) begin
      if (insert && !keep[i]) begin
        cell_burst_r[i] <= prev_keep ? new_burst : prev_burst;
        cell_id_r[i]    <= prev_keep ? new_id    : prev_id;
      end else if (cmd.pop) begin
        cell_burst_r[i] <= next_burst;
        cell_id_r[i]    <= next_id;
      end
    end
  end

  // Saturating time sums for the job at the head of the array
  assign last_pop = (cnt_r == CNT_W'(1));
  assign ta_sum   = {1'b0, wait_r} + (WAIT_W + 1)'(cell_burst_r[0]);
  assign ta       = ta_sum[WAIT_W] ? WAIT_MAX : ta_sum[WAIT_W-1:0];
  assign tw_sum   = {1'b0, totw_r} + (TOTAL_W + 1)'(wait_r);
  assign tt_sum   = {1'b0, tott_r} + (TOTAL_W + 1)'(ta);
  assign tw       = tw_sum[TOTAL_W] ? TOTAL_MAX : tw_sum[TOTAL_W-1:0];
  assign tt       = tt_sum[TOTAL_W] ? TOTAL_MAX : tt_sum[TOTAL_W-1:0];

  // Job count, overflow flag and running sums; all cleared after the final pop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      wait_r <= '0;
      totw_r <= '0;
      tott_r <= '0;
    end else if (accept) begin
      if (full) begin
        ovf_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end else if (cmd.pop) begin
      if (last_pop) begin
        cnt_r  <= '0;
        ovf_r  <= 1'b0;
        wait_r <= '0;
        totw_r <= '0;
        tott_r <= '0;
      end else begin
        cnt_r  <= cnt_r - CNT_W'(1);
        wait_r <= ta;
        totw_r <= tw;
        tott_r <= tt;
      end
    end
  end

  // Result register valid flag
  assign out_free = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.pop) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      job_id_r     <= JOB_ID_W'(cell_id_r[0]) + JOB_ID_W'(1);
      job_burst_r  <= BURST_W'(cell_burst_r[0]);
      wait_time_r  <= wait_r;
      turnaround_r <= ta;
      total_wait_r <= last_pop ? tw : '0;
      total_turn_r <= last_pop ? tt : '0;
      final_r      <= last_pop;
      dropped_r    <= ovf_r;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.job_id           = job_id_r;
  assign out_chan.job_burst        = job_burst_r;
  assign out_chan.wait_time        = wait_time_r;
  assign out_chan.turnaround       = turnaround_r;
  assign out_chan.total_wait       = total_wait_r;
  assign out_chan.total_turnaround = total_turn_r;
  assign out_chan.final_res        = final_r;
  assign out_chan.dropped          = dropped_r;

  // Status to the controller
  assign sts.in_valid = in_chan.valid;
  assign sts.in_last  = in_chan.batch_end;
  assign sts.out_free = out_free;
  assign sts.last_pop = last_pop;

endmodule

### rtl/longest_job_first_schedule_top.sv
// Top level of the longest-job-first scheduler: controller and datapath.
//
//   Channel   Direction  Handshake               Carries
//   in_chan   in         valid/ready             burst, batch_end
//   out_chan  out        valid/ready             job_id, job_burst, wait_time, turnaround,
//                                                total_wait, total_turnaround, final_res,
//                                                dropped
//
// While loading, one request is taken every cycle; the cell array places each burst in
// sorted position in the cycle it arrives; a request beyond MAX_JOBS is dropped.
// The request marked last starts the schedule: the batch then leaves from the head cell at
// one result per cycle unless the result channel stalls, and no request is taken meanwhile.
// A stall on the result channel holds the result register and pauses the schedule.
// Reset is synchronous and active low; it empties the batch and clears the result flag.
module longest_job_first_schedule_top import ljf_pkg::*; #(
  parameter int unsigned MAX_JOBS   = 64,
  parameter int unsigned BURST_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  ljf_in_if.sink    in_chan,
  ljf_out_if.source out_chan
);

  ljf_cmd_t cmd;
  ljf_sts_t sts;

  // Sequencing
  ljf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  // Storage and arithmetic
  ljf_dp #(
    .MAX_JOBS   (MAX_JOBS),
    .BURST_BITS (BURST_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule
